### rtl/core/pba_pkg.sv
// Shared constants, codes and types of the page bitmap allocator.
package pba_pkg;

    localparam int NUM_PAGES  = 4096;
    localparam int PAGE_W     = $clog2(NUM_PAGES);
    localparam int CNT_W      = PAGE_W + 1;
    localparam int END_W      = CNT_W + 1;
    localparam int WORD_W     = 16;
    localparam int WIDX_W     = $clog2(WORD_W);
    localparam int ADDR_W     = PAGE_W - WIDX_W;
    localparam int NUM_WORDS  = NUM_PAGES / WORD_W;
    localparam int DELTA_W    = WIDX_W + 1;
    localparam int FUNC_W     = 3;
    localparam int S_TDATA_W  = ((PAGE_W + CNT_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((PAGE_W + 3 * CNT_W + 7) / 8) * 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_REQUEST   = 3'd0,
        FUNC_FREE      = 3'd1,
        FUNC_LOCK      = 3'd2,
        FUNC_RESERVE   = 3'd3,
        FUNC_UNRESERVE = 3'd4
    } func_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_RANGE,
        ST_HINT_RD,
        ST_HINT,
        ST_DONE
    } state_t;

    // per-word controls for the bitmap word logic
    typedef struct packed {
        logic              set_bit;
        logic [WIDX_W-1:0] lo;
        logic [WIDX_W-1:0] hi;
    } wop_ctl_t;

    typedef struct packed {
        logic [WORD_W-1:0]  new_word;
        logic [DELTA_W-1:0] change_cnt;
        logic               change_any;
        logic [WIDX_W-1:0]  change_first;
        logic               scan_found;
        logic [WIDX_W-1:0]  scan_pos;
        logic [CNT_W-1:0]   run_out;
        logic               zero_found;
        logic [WIDX_W-1:0]  zero_pos;
    } wop_res_t;

    typedef struct packed {
        logic               en;
        logic               set_bit;
        logic               to_used;
        logic [DELTA_W-1:0] delta;
    } cnt_upd_t;

endpackage

### rtl/core/pba_ram.sv
// Generic simple dual-port RAM with registered read.
module pba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/pba_word_ops.sv
// Bitmap word logic: range set/clear, run search and first-clear search.
module pba_word_ops (
    input  pba_pkg::wop_ctl_t              ctl,
    input  logic [pba_pkg::WORD_W-1:0]     word,
    input  logic [pba_pkg::CNT_W-1:0]      run_in,
    input  logic [pba_pkg::CNT_W-1:0]      count,
    output pba_pkg::wop_res_t              res
);
    import pba_pkg::*;

    always_comb begin
        logic [WORD_W-1:0] mask;
        logic [WORD_W-1:0] change;
        logic [WORD_W-1:0] busy_m;
        logic [CNT_W-1:0]  run_j;
        logic              last_f;
        logic [WIDX_W-1:0] last_i;

        res = '0;
        for (int i = 0; i < WORD_W; i++) begin
            mask[i]   = (WIDX_W'(i) >= ctl.lo) && (WIDX_W'(i) <= ctl.hi);
            // pages below the start offset count as busy for the searches
            busy_m[i] = word[i] | (WIDX_W'(i) < ctl.lo);
        end
        change       = ctl.set_bit ? (mask & ~word) : (mask & word);
        res.new_word = ctl.set_bit ? (word | mask) : (word & ~mask);

        for (int i = WORD_W - 1; i >= 0; i--) begin
            res.change_cnt = res.change_cnt + DELTA_W'(change[i]);
            if (change[i]) begin
                res.change_any   = 1'b1;
                res.change_first = WIDX_W'(i);
            end
            if (!busy_m[i]) begin
                res.zero_found = 1'b1;
                res.zero_pos   = WIDX_W'(i);
            end
        end

        // run length ending at each bit, from the last busy bit at or below it
        run_j = '0;
        for (int j = 0; j < WORD_W; j++) begin
            last_f = 1'b0;
            last_i = '0;
            for (int k = 0; k < WORD_W; k++) begin
                if (k <= j && busy_m[k]) begin
                    last_f = 1'b1;
                    last_i = WIDX_W'(k);
                end
            end
            run_j = last_f ? CNT_W'(WIDX_W'(j) - last_i) : run_in + CNT_W'(j + 1);
            if (run_j >= count && !res.scan_found) begin
                res.scan_found = 1'b1;
                res.scan_pos   = WIDX_W'(j);
            end
        end
        res.run_out = run_j;
    end

endmodule

### rtl/core/pba_counters.sv
// Saturating free, used and reserved page counters.
module pba_counters (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  pba_pkg::cnt_upd_t           upd,
    output logic [pba_pkg::CNT_W-1:0]   free_pages,
    output logic [pba_pkg::CNT_W-1:0]   used_pages,
    output logic [pba_pkg::CNT_W-1:0]   reserved_pages
);
    import pba_pkg::*;

    logic [CNT_W-1:0] free_reg, free_next;
    logic [CNT_W-1:0] used_reg, used_next;
    logic [CNT_W-1:0] rsvd_reg, rsvd_next;

    function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] v, logic [DELTA_W-1:0] d);
        logic [CNT_W:0] sum;
        sum = {1'b0, v} + (CNT_W + 1)'(d);
        return (sum > (CNT_W + 1)'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : sum[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] sat_sub(logic [CNT_W-1:0] v, logic [DELTA_W-1:0] d);
        return (v < CNT_W'(d)) ? '0 : v - CNT_W'(d);
    endfunction

    always_comb begin
        free_next = free_reg;
        used_next = used_reg;
        rsvd_next = rsvd_reg;
        if (upd.en) begin
            if (upd.set_bit) begin
                free_next = sat_sub(free_reg, upd.delta);
                if (upd.to_used) begin
                    used_next = sat_add(used_reg, upd.delta);
                end else begin
                    rsvd_next = sat_add(rsvd_reg, upd.delta);
                end
            end else begin
                free_next = sat_add(free_reg, upd.delta);
                if (upd.to_used) begin
                    used_next = sat_sub(used_reg, upd.delta);
                end else begin
                    rsvd_next = sat_sub(rsvd_reg, upd.delta);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_reg <= CNT_W'(NUM_PAGES);
            used_reg <= '0;
            rsvd_reg <= '0;
        end else begin
            free_reg <= free_next;
            used_reg <= used_next;
            rsvd_reg <= rsvd_next;
        end
    end

    assign free_pages     = free_reg;
    assign used_pages     = used_reg;
    assign reserved_pages = rsvd_reg;

endmodule

### rtl/core/page_bitmap_allocator.sv
// Bitmap page allocator: first-fit run requests and range free/lock/reserve/unreserve.
// One op at a time, one 16-page word per cycle; a result stall holds only the next op's end.
// Range op: accept, decode, then one pass over the words the range spans, then the result beat.
// Request: decode, scan words from the hint, lock the run's words, then search for the new hint.
// Zero count or ignored: decode straight to result; failed request: scan words first (none if rejected early).
// Next op taken in ST_IDLE after its result loads. Reset: all 256 bitmap words cleared, s_tready low.
module page_bitmap_allocator (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // page_index [11:0], page_count [24:12], zero pad
    input  logic [pba_pkg::S_TDATA_W-1:0]     s_tdata,
    // func [2:0]
    input  logic [pba_pkg::FUNC_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // start_page [11:0], free_pages [24:12], used_pages [37:25],
    // reserved_pages [50:38], zero pad
    output logic [pba_pkg::M_TDATA_W-1:0]     m_tdata,
    // status [0]
    output logic                              m_tuser
);
    import pba_pkg::*;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic [FUNC_W-1:0]   op_reg, op_next;
    logic [PAGE_W-1:0]   index_reg, index_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [PAGE_W-1:0]   range_first_reg, range_first_next;
    logic [PAGE_W-1:0]   range_last_reg, range_last_next;
    logic [CNT_W-1:0]    hint_reg, hint_next;
    logic [CNT_W-1:0]    run_reg, run_next;
    logic                first_word_reg, first_word_next;
    logic [PAGE_W-1:0]   res_start_reg, res_start_next;
    logic                res_status_reg, res_status_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   ram_rdata;

    wop_ctl_t            wctl;
    wop_res_t            wres;
    cnt_upd_t            cupd;
    logic [CNT_W-1:0]    free_pages, used_pages, reserved_pages;

    logic                is_req;
    logic                set_bit;
    logic                to_used;
    logic                decode_skip;
    logic                decode_fail;
    logic                last_addr;
    logic                out_free;
    logic [END_W-1:0]    range_end;
    logic [PAGE_W-1:0]   pos_abs;
    logic [PAGE_W-1:0]   run_start;
    logic [PAGE_W-1:0]   chg_abs;
    logic [PAGE_W-1:0]   zero_abs;

    pba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_bitmap (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cur_addr_next),
        .rdata (ram_rdata)
    );

    pba_word_ops u_word_ops (
        .ctl    (wctl),
        .word   (ram_rdata),
        .run_in (run_reg),
        .count  (count_reg),
        .res    (wres)
    );

    pba_counters u_counters (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .upd            (cupd),
        .free_pages     (free_pages),
        .used_pages     (used_pages),
        .reserved_pages (reserved_pages)
    );

    assign is_req  = (op_reg == FUNC_REQUEST);
    assign set_bit = (op_reg == FUNC_REQUEST) || (op_reg == FUNC_LOCK) ||
                     (op_reg == FUNC_RESERVE);
    assign to_used = (op_reg == FUNC_REQUEST) || (op_reg == FUNC_LOCK) ||
                     (op_reg == FUNC_FREE);

    assign decode_fail = is_req && (count_reg != '0) &&
                         ((count_reg > CNT_W'(NUM_PAGES)) || hint_reg[PAGE_W]);
    assign decode_skip = (count_reg == '0) || (op_reg > FUNC_UNRESERVE) ||
                         ((op_reg == FUNC_FREE) && (index_reg == '0)) || decode_fail;

    assign last_addr = (cur_addr_reg == ADDR_W'(NUM_WORDS - 1));
    assign out_free  = !m_tvalid_reg || m_tready;
    assign range_end = END_W'(index_reg) + END_W'(count_reg);
    assign pos_abs   = {cur_addr_reg, wres.scan_pos};
    assign run_start = PAGE_W'({1'b0, pos_abs} + CNT_W'(1) - count_reg);
    assign chg_abs   = {cur_addr_reg, wres.change_first};
    assign zero_abs  = {cur_addr_reg, wres.zero_pos};

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (last_addr) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (decode_skip) begin
                    state_next = ST_DONE;
                end else if (is_req) begin
                    state_next = ST_SCAN;
                end else begin
                    state_next = ST_RANGE;
                end
            end
            ST_SCAN: begin
                if (wres.scan_found) begin
                    state_next = ST_RANGE;
                end else if (last_addr) begin
                    state_next = ST_DONE;
                end
            end
            ST_RANGE: begin
                if (cur_addr_reg == range_last_reg[PAGE_W-1:WIDX_W]) begin
                    state_next = is_req ? ST_HINT_RD : ST_DONE;
                end
            end
            ST_HINT_RD: begin
                state_next = ST_HINT;
            end
            ST_HINT: begin
                if (wres.zero_found || last_addr) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs: s_tready, RAM write, word logic controls, counter update
    always_comb begin
        s_tready     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cur_addr_reg;
        ram_wdata    = wres.new_word;
        wctl.set_bit = set_bit;
        wctl.lo      = '0;
        wctl.hi      = '1;
        cupd.en      = 1'b0;
        cupd.set_bit = set_bit;
        cupd.to_used = to_used;
        cupd.delta   = wres.change_cnt;
        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SCAN, ST_HINT: begin
                wctl.lo = first_word_reg ? hint_reg[WIDX_W-1:0] : '0;
            end
            ST_RANGE: begin
                if (cur_addr_reg == range_first_reg[PAGE_W-1:WIDX_W]) begin
                    wctl.lo = range_first_reg[WIDX_W-1:0];
                end
                if (cur_addr_reg == range_last_reg[PAGE_W-1:WIDX_W]) begin
                    wctl.hi = range_last_reg[WIDX_W-1:0];
                end
                ram_we  = 1'b1;
                cupd.en = 1'b1;
            end
            ST_DECODE, ST_HINT_RD, ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // datapath; cur_addr_next is also the RAM read address
    always_comb begin
        cur_addr_next    = cur_addr_reg;
        op_next          = op_reg;
        index_next       = index_reg;
        count_next       = count_reg;
        range_first_next = range_first_reg;
        range_last_next  = range_last_reg;
        hint_next        = hint_reg;
        run_next         = run_reg;
        first_word_next  = first_word_reg;
        res_start_next   = res_start_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        case (state_reg)
            ST_CLEAR: begin
                cur_addr_next = cur_addr_reg + 1'b1;
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next    = s_tuser;
                    index_next = s_tdata[PAGE_W-1:0];
                    count_next = s_tdata[PAGE_W+CNT_W-1:PAGE_W];
                end
            end
            ST_DECODE: begin
                res_start_next  = '0;
                res_status_next = decode_fail;
                run_next        = '0;
                first_word_next = 1'b1;
                range_first_next = index_reg;
                if (range_end > END_W'(NUM_PAGES)) begin
                    range_last_next = PAGE_W'(NUM_PAGES - 1);
                end else begin
                    range_last_next = PAGE_W'(range_end - 1'b1);
                end
                cur_addr_next = is_req ? hint_reg[PAGE_W-1:WIDX_W]
                                       : index_reg[PAGE_W-1:WIDX_W];
            end
            ST_SCAN: begin
                if (wres.scan_found) begin
                    range_first_next = run_start;
                    range_last_next  = pos_abs;
                    res_start_next   = run_start;
                    cur_addr_next    = run_start[PAGE_W-1:WIDX_W];
                end else begin
                    run_next        = wres.run_out;
                    first_word_next = 1'b0;
                    cur_addr_next   = cur_addr_reg + 1'b1;
                    if (last_addr) begin
                        res_status_next = 1'b1;
                    end
                end
            end
            ST_RANGE: begin
                cur_addr_next = cur_addr_reg + 1'b1;
                // a cleared page pulls the hint down
                if (!set_bit && wres.change_any && (CNT_W'(chg_abs) < hint_reg)) begin
                    hint_next = CNT_W'(chg_abs);
                end
            end
            ST_HINT_RD: begin
                first_word_next = 1'b1;
                cur_addr_next   = hint_reg[PAGE_W-1:WIDX_W];
            end
            ST_HINT: begin
                first_word_next = 1'b0;
                cur_addr_next   = cur_addr_reg + 1'b1;
                if (wres.zero_found) begin
                    hint_next = CNT_W'(zero_abs);
                end else if (last_addr) begin
                    hint_next = CNT_W'(NUM_PAGES);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_TDATA_W'({reserved_pages, used_pages,
                                                free_pages, res_start_reg});
                    m_tuser_next  = res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            cur_addr_reg <= '0;
            hint_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cur_addr_reg <= cur_addr_next;
            hint_reg     <= hint_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        index_reg       <= index_next;
        count_reg       <= count_next;
        range_first_reg <= range_first_next;
        range_last_reg  <= range_last_next;
        run_reg         <= run_next;
        first_word_reg  <= first_word_next;
        res_start_reg   <= res_start_next;
        res_status_reg  <= res_status_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

### test/page_bitmap_allocator_test.sv
// Self-checking testbench for the page bitmap allocator: predictor, stimulus and result checks.
`timescale 1ns / 1ps

module page_bitmap_allocator_test;
    import pba_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;
    localparam int MAX_COUNT   = 2**CNT_W - 1;
    localparam int TAIL_CYCLES = 16;
    localparam int SHOW_LIMIT  = 10;

    typedef struct {
        logic [PAGE_W-1:0] start_page;
        logic              oom;
        logic [CNT_W-1:0]  free_pages;
        logic [CNT_W-1:0]  used_pages;
        logic [CNT_W-1:0]  reserved_pages;
    } alloc_result_t;

    typedef struct {
        int first;
        int count;
    } grant_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]    s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int hold_cycles     = 0;
    int mismatches      = 0;

    // predicted allocator state
    bit            page_taken [NUM_PAGES];
    int            hint_page      = 0;
    int            free_total     = NUM_PAGES;
    int            used_total     = 0;
    int            reserved_total = 0;
    alloc_result_t expected_results[$];
    grant_t        live_grants[$];

    page_bitmap_allocator dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic int sat_dec(int v);
        return (v == 0) ? 0 : v - 1;
    endfunction

    function automatic int sat_inc(int v);
        return (v >= NUM_PAGES) ? NUM_PAGES : v + 1;
    endfunction

    function automatic void touch_page(int p, logic [FUNC_W-1:0] fn);
        if (p >= NUM_PAGES)
            return;
        if (fn == FUNC_LOCK || fn == FUNC_RESERVE) begin
            if (page_taken[p])
                return;
            page_taken[p] = 1'b1;
            free_total = sat_dec(free_total);
            if (fn == FUNC_LOCK)
                used_total = sat_inc(used_total);
            else
                reserved_total = sat_inc(reserved_total);
        end else begin
            if (!page_taken[p])
                return;
            page_taken[p] = 1'b0;
            free_total = sat_inc(free_total);
            // free drops the used count even when the page was reserved
            if (fn == FUNC_FREE)
                used_total = sat_dec(used_total);
            else
                reserved_total = sat_dec(reserved_total);
            if (hint_page > p)
                hint_page = p;
        end
    endfunction

    function automatic void touch_range(int first, int count, logic [FUNC_W-1:0] fn);
        for (int i = 0; i < count; i++) begin
            if (first + i >= NUM_PAGES)
                break;
            touch_page(first + i, fn);
        end
    endfunction

    // first fit from the hint; locks the run and moves the hint on success
    function automatic bit grant_run(int count, output int first);
        int  run_len;
        bit  found;
        run_len = 0;
        found   = 1'b0;
        first   = 0;
        for (int p = hint_page; p < NUM_PAGES; p++) begin
            if (page_taken[p]) begin
                run_len = 0;
            end else begin
                run_len++;
                if (run_len == count) begin
                    first = p + 1 - count;
                    found = 1'b1;
                    break;
                end
            end
        end
        if (!found)
            return 1'b0;
        touch_range(first, count, FUNC_LOCK);
        while (hint_page < NUM_PAGES && page_taken[hint_page])
            hint_page++;
        return 1'b1;
    endfunction

    function automatic void predict_op(logic [FUNC_W-1:0] fn, int idx, int cnt);
        alloc_result_t r;
        int            first;
        grant_t        g;
        r.start_page = '0;
        r.oom        = 1'b0;
        if (cnt != 0) begin
            case (fn)
                FUNC_REQUEST: begin
                    if (grant_run(cnt, first)) begin
                        r.start_page = first[PAGE_W-1:0];
                        g.first = first;
                        g.count = cnt;
                        live_grants.push_back(g);
                    end else begin
                        r.oom = 1'b1;
                    end
                end
                FUNC_FREE: begin
                    if (idx != 0)
                        touch_range(idx, cnt, fn);
                end
                FUNC_LOCK, FUNC_RESERVE, FUNC_UNRESERVE: begin
                    touch_range(idx, cnt, fn);
                end
                default: ;
            endcase
        end
        r.free_pages     = free_total[CNT_W-1:0];
        r.used_pages     = used_total[CNT_W-1:0];
        r.reserved_pages = reserved_total[CNT_W-1:0];
        expected_results.push_back(r);
    endfunction

    // leaves tvalid high after the beat is taken; the next call decides
    task automatic send_op(logic [FUNC_W-1:0] fn, int idx, int cnt);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[PAGE_W-1:0]      = idx[PAGE_W-1:0];
        word[PAGE_W +: CNT_W] = cnt[CNT_W-1:0];
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= fn;
        do
            @(posedge aclk);
        while (s_tready !== 1'b1);
        predict_op(fn, idx, cnt);
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_op();
        int                r;
        int                idx;
        int                cnt;
        int                slot;
        logic [FUNC_W-1:0] fn;
        r   = $urandom_range(99);
        idx = $urandom_range(NUM_PAGES - 1);
        if (r < 3)
            cnt = 0;
        else if (r < 70)
            cnt = $urandom_range(16, 1);
        else if (r < 90)
            cnt = $urandom_range(128, 17);
        else if (r < 97)
            cnt = $urandom_range(1024, 129);
        else
            cnt = $urandom_range(MAX_COUNT, 1025);
        r = $urandom_range(99);
        if (r < 38) begin
            fn = FUNC_REQUEST;
        end else if (r < 60) begin
            fn = FUNC_FREE;
            // mostly hand back a run that was granted earlier
            if (live_grants.size() != 0 && $urandom_range(3) != 0) begin
                slot = $urandom_range(live_grants.size() - 1);
                idx  = live_grants[slot].first;
                cnt  = live_grants[slot].count;
                live_grants.delete(slot);
            end
        end else if (r < 72) begin
            fn = FUNC_LOCK;
        end else if (r < 84) begin
            fn = FUNC_RESERVE;
        end else if (r < 97) begin
            fn = FUNC_UNRESERVE;
        end else begin
            fn = FUNC_W'($urandom_range(FUNC_UNUSED_LAST, FUNC_UNUSED_FIRST));
        end
        send_op(fn, idx, cnt);
    endtask

    task automatic test_corner_cases();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        send_op(FUNC_REQUEST, 0, 0);
        send_op(FUNC_REQUEST, 0, 1);
        send_op(FUNC_REQUEST, 4095, 16);
        send_op(FUNC_LOCK, 40, 8);
        send_op(FUNC_RESERVE, 100, 20);
        send_op(FUNC_REQUEST, 0, 30);
        send_op(FUNC_FREE, 0, 10);
        send_op(FUNC_FREE, 5, 3);
        send_op(FUNC_LOCK, 300, 0);
        send_op(FUNC_UNRESERVE, 110, 5);
        send_op(FUNC_REQUEST, 0, 2);
        send_op(FUNC_FREE, 4095, 1);
        send_op(FUNC_RESERVE, 4090, 100);
        send_op(FUNC_UNRESERVE, 4094, MAX_COUNT);
        for (int f = int'(FUNC_UNUSED_FIRST); f <= int'(FUNC_UNUSED_LAST); f++)
            send_op(f[FUNC_W-1:0], 'h555, 'hAAA);
        send_op(FUNC_FREE, 100, 10);
        send_op(FUNC_REQUEST, 0, NUM_PAGES);
        send_op(FUNC_REQUEST, 0, MAX_COUNT);
        send_op(FUNC_LOCK, 0, NUM_PAGES);
        send_op(FUNC_REQUEST, 0, 1);
        send_op(FUNC_FREE, 1, NUM_PAGES - 1);
        send_op(FUNC_UNRESERVE, 0, NUM_PAGES);
        // reserved pages released through free pull the used count down to zero
        send_op(FUNC_RESERVE, 'h555, 'hAA);
        send_op(FUNC_FREE, 'h555, 'hAA);
        wait_all_results();
    endtask

    task automatic test_traffic(int idle_pct, int stall_pct, int n_ops);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (n_ops) send_random_op();
        wait_all_results();
    endtask

    // result side blocked for a long stretch while ops keep coming
    task automatic test_output_stall();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_cycles     = 1500;
        repeat (24) send_random_op();
        wait_all_results();
    endtask

    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic void compare_field(string name, logic [CNT_W-1:0] want,
                                          logic [CNT_W-1:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT)
                $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOW_LIMIT)
                    $display("%0t: result beat with nothing outstanding, tdata %h",
                             $realtime, m_tdata);
            end else begin
                want = expected_results.pop_front();
                compare_field("start_page", CNT_W'(want.start_page),
                              CNT_W'(m_tdata[PAGE_W-1:0]));
                compare_field("status", CNT_W'(want.oom), CNT_W'(m_tuser));
                compare_field("free_pages", want.free_pages, m_tdata[PAGE_W +: CNT_W]);
                compare_field("used_pages", want.used_pages,
                              m_tdata[PAGE_W + CNT_W +: CNT_W]);
                compare_field("reserved_pages", want.reserved_pages,
                              m_tdata[PAGE_W + 2 * CNT_W +: CNT_W]);
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_corner_cases();
        test_traffic(0, 0, 225);
        test_traffic(57, 0, 225);
        test_traffic(0, 57, 225);
        test_output_stall();
        test_traffic(25, 25, 225);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### filelist.f
rtl/core/pba_pkg.sv
rtl/core/pba_ram.sv
rtl/core/pba_word_ops.sv
rtl/core/pba_counters.sv
rtl/core/page_bitmap_allocator.sv
test/page_bitmap_allocator_test.sv
